// ===== rtl/adjacency_bit_matrix_unit_defines.svh =====
// Assertion macros for the adjacency bit matrix unit.
`ifndef ADJACENCY_BIT_MATRIX_UNIT_DEFINES_SVH
`define ADJACENCY_BIT_MATRIX_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ABM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`define ABM_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`else
`define ABM_ASSERT(lbl, prop, msg)
`define ABM_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

// ===== rtl/abm_pkg.sv =====
package abm_pkg;

  localparam int MAX_NODES   = 64;
  localparam int ADDR_W      = $clog2(MAX_NODES);
  localparam int ROW_W       = 64;
  localparam int NODE_W      = 6;
  localparam int IN_NODE_W   = 8;
  localparam int CNT_W       = 7;
  localparam int OP_W        = 3;
  localparam int CHUNK_W     = 8;
  localparam int NCHUNK      = ROW_W / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(NCHUNK);
  localparam int BIT_IDX_W   = $clog2(CHUNK_W);
  localparam int STEP_W      = $clog2(IN_NODE_W);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_QUERY = 3'd1,
    OP_DEG   = 3'd2,
    OP_LIST  = 3'd3,
    OP_CLEAR = 3'd4,
    OP_COMPL = 3'd5
  } abm_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_RD_A,
    S_RD_B,
    S_QRY,
    S_SCAN,
    S_CMP,
    S_RES
  } abm_state_t;

  typedef struct packed {
    logic              status;
    logic              edge_present;
    logic [NODE_W-1:0] degree;
    logic [NODE_W-1:0] neighbor;
    logic              neighbor_valid;
    logic              last;
  } abm_result_t;

  typedef struct packed {
    logic start;
    logic list_mode;
  } abm_scan_ctl_t;

endpackage

// ===== rtl/abm_ram.sv =====
module abm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/abm_mod_unit.sv =====
module abm_mod_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [abm_pkg::IN_NODE_W-1:0]  a_in,
  input  logic [abm_pkg::IN_NODE_W-1:0]  b_in,
  input  logic [abm_pkg::CNT_W-1:0]      n_in,
  output logic                           done,
  output logic [abm_pkg::NODE_W-1:0]     a_mod,
  output logic [abm_pkg::NODE_W-1:0]     b_mod
);
  import abm_pkg::*;

  localparam int CAND_W = IN_NODE_W + CNT_W;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_W-1:0]    k_r, k_nxt;
  logic [IN_NODE_W-1:0] rem_a_r, rem_a_nxt;
  logic [IN_NODE_W-1:0] rem_b_r, rem_b_nxt;
  logic [CAND_W-1:0]    cand;

  function automatic logic [IN_NODE_W-1:0] sub_step(logic [IN_NODE_W-1:0] r,
                                                     logic [CAND_W-1:0] c);
    logic [CAND_W-1:0] rx;
    rx = CAND_W'(r);
    if (rx >= c) begin
      rx = rx - c;
    end
    return rx[IN_NODE_W-1:0];
  endfunction

  assign cand = CAND_W'(n_in) << k_r;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    k_nxt     = k_r;
    rem_a_nxt = rem_a_r;
    rem_b_nxt = rem_b_r;
    if (start) begin
      busy_nxt  = 1'b1;
      k_nxt     = STEP_W'(IN_NODE_W - 1);
      rem_a_nxt = a_in;
      rem_b_nxt = b_in;
    end else if (busy_r) begin
      rem_a_nxt = sub_step(rem_a_r, cand);
      rem_b_nxt = sub_step(rem_b_r, cand);
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    k_r     <= k_nxt;
    rem_a_r <= rem_a_nxt;
    rem_b_r <= rem_b_nxt;
  end

  assign done  = done_r;
  assign a_mod = rem_a_r[NODE_W-1:0];
  assign b_mod = rem_b_r[NODE_W-1:0];

endmodule

// ===== rtl/abm_row_scan.sv =====
module abm_row_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  abm_pkg::abm_scan_ctl_t      ctl,
  input  logic [abm_pkg::ROW_W-1:0]   row_in,
  input  logic                        out_free,
  output logic                        res_valid,
  output abm_pkg::abm_result_t        res
);
  import abm_pkg::*;

  logic                   active_r, active_nxt;
  logic                   list_r, list_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [CHUNK_IDX_W-1:0] chunk_r, chunk_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CHUNK_W-1:0]     cur;
  logic [BIT_IDX_W:0]     pc;
  logic [BIT_IDX_W-1:0]   low;
  logic [ROW_W-1:0]       row_clr;
  logic [CNT_W-1:0]       deg_sum;

  assign cur = row_r[{chunk_r, {BIT_IDX_W{1'b0}}} +: CHUNK_W];

  always_comb begin
    pc  = '0;
    low = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      pc = pc + (BIT_IDX_W + 1)'(cur[i]);
      if (cur[i]) begin
        low = BIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    row_clr = row_r;
    row_clr[{chunk_r, low}] = 1'b0;
  end

  assign deg_sum = cnt_r + CNT_W'(pc);

  always_comb begin
    active_nxt = active_r;
    list_nxt   = list_r;
    row_nxt    = row_r;
    chunk_nxt  = chunk_r;
    cnt_nxt    = cnt_r;
    res_valid  = 1'b0;
    res        = '0;
    res.last   = 1'b1;
    if (ctl.start) begin
      active_nxt = 1'b1;
      list_nxt   = ctl.list_mode;
      row_nxt    = row_in;
      chunk_nxt  = '0;
      cnt_nxt    = '0;
    end else if (active_r && !list_r) begin
      if (chunk_r == CHUNK_IDX_W'(NCHUNK - 1)) begin
        if (out_free) begin
          res_valid  = 1'b1;
          res.degree = deg_sum[NODE_W-1:0];
          active_nxt = 1'b0;
        end
      end else begin
        cnt_nxt   = deg_sum;
        chunk_nxt = chunk_r + 1'b1;
      end
    end else if (active_r) begin
      if (row_r == '0) begin
        if (out_free) begin
          res_valid  = 1'b1;
          active_nxt = 1'b0;
        end
      end else if (cur == '0) begin
        chunk_nxt = chunk_r + 1'b1;
      end else if (out_free) begin
        res_valid          = 1'b1;
        res.neighbor       = NODE_W'({chunk_r, low});
        res.neighbor_valid = 1'b1;
        res.last           = (row_clr == '0);
        row_nxt            = row_clr;
        if (row_clr == '0) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    list_r  <= list_nxt;
    row_r   <= row_nxt;
    chunk_r <= chunk_nxt;
    cnt_r   <= cnt_nxt;
  end

endmodule

// ===== rtl/adjacency_bit_matrix_unit.sv =====
// Listing gives one result per neighbor and passes over empty bytes; complement sweeps the
// rows one row per cycle, writing each row while reading the next through separate ports.
// One request at a time; the next is taken once the last result is registered.
// Synchronous active-low reset clears control, the row valid bits (empty graph)
// and sets node_count to 64; no clearing pass over the memory.
`include "adjacency_bit_matrix_unit_defines.svh"

module adjacency_bit_matrix_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [abm_pkg::OP_W-1:0]           in_opcode,
  input  logic [abm_pkg::IN_NODE_W-1:0]      in_node_a,
  input  logic [abm_pkg::IN_NODE_W-1:0]      in_node_b,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_status,
  output logic                               out_edge_present,
  output logic [abm_pkg::NODE_W-1:0]         out_degree,
  output logic [abm_pkg::NODE_W-1:0]         out_neighbor,
  output logic                               out_neighbor_valid,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [abm_pkg::CNT_W-1:0]          cfg_data
);
  import abm_pkg::*;

  abm_state_t           state_r, state_nxt;
  abm_op_t              op_r, op_nxt;
  logic [IN_NODE_W-1:0] a_r, a_nxt;
  logic [IN_NODE_W-1:0] b_r, b_nxt;
  logic [ADDR_W-1:0]    cidx_r, cidx_nxt;
  abm_result_t          pend_r, pend_nxt;
  logic [MAX_NODES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]     node_count_r;
  logic                 rd_vld_r;
  logic                 out_valid_r, out_valid_nxt;
  abm_result_t          out_res_r, out_res_nxt;

  logic                 acc;
  abm_op_t              in_op;
  logic [CNT_W-1:0]     n_eff;
  logic [ROW_W-1:0]     live;
  logic [ROW_W-1:0]     all_nodes;
  logic                 err_a, err_b;
  logic                 out_free;
  logic                 load_en;
  abm_result_t          load_res;
  abm_result_t          ok_res;

  logic                 wr_en, rd_en;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic [ROW_W-1:0]     wr_data, rd_data, rd_row, q_row;

  logic                 mod_start, mod_done;
  logic [NODE_W-1:0]    a_mod, b_mod;

  abm_scan_ctl_t        scan_ctl;
  logic                 scan_vld;
  abm_result_t          scan_res;

  function automatic logic [ROW_W-1:0] node_bit(logic [NODE_W-1:0] i);
    return ROW_W'(1) << i;
  endfunction

  assign in_op  = abm_op_t'(in_opcode);
  assign acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (node_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count_r > CNT_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      live[i]      = (CNT_W'(i) < n_eff);
      all_nodes[i] = (i < MAX_NODES);
    end
  end

  assign err_a    = (in_node_a >= IN_NODE_W'(n_eff));
  assign err_b    = (in_node_b >= IN_NODE_W'(n_eff));
  assign out_free = !out_valid_r || !out_stall;
  assign rd_row   = rd_vld_r ? rd_data : '0;
  assign q_row    = rd_row & live & ~node_bit(a_r[NODE_W-1:0]);

  always_comb begin
    ok_res      = '0;
    ok_res.last = 1'b1;
  end

  abm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_NODES)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  abm_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .a_in  (in_node_a),
    .b_in  (in_node_b),
    .n_in  (n_eff),
    .done  (mod_done),
    .a_mod (a_mod),
    .b_mod (b_mod)
  );

  abm_row_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .row_in    (q_row),
    .out_free  (out_free),
    .res_valid (scan_vld),
    .res       (scan_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_op)
            OP_ADD:   state_nxt = S_MOD;
            OP_QUERY: state_nxt = (err_a || err_b) ? S_RES : S_QRY;
            OP_DEG:   state_nxt = err_a ? S_RES : S_QRY;
            OP_LIST:  state_nxt = err_a ? S_RES : S_QRY;
            OP_COMPL: state_nxt = S_CMP;
            default:  state_nxt = S_RES;
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_nxt = (a_mod == b_mod) ? S_RES : S_RD_A;
        end
      end
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: state_nxt = S_RES;
      S_QRY:  state_nxt = (op_r == OP_QUERY) ? S_RES : S_SCAN;
      S_SCAN: begin
        if (scan_vld && scan_res.last) begin
          state_nxt = S_IDLE;
        end
      end
      S_CMP: begin
        if (cidx_r == ADDR_W'(MAX_NODES - 1)) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt    = op_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    cidx_nxt  = cidx_r;
    pend_nxt  = pend_r;
    valid_nxt = valid_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    mod_start = 1'b0;
    scan_ctl  = '0;
    load_en   = 1'b0;
    load_res  = pend_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          op_nxt   = in_op;
          a_nxt    = in_node_a;
          b_nxt    = in_node_b;
          pend_nxt = ok_res;
          case (in_op)
            OP_ADD: begin
              mod_start = 1'b1;
              a_nxt     = in_node_a;
            end
            OP_QUERY: begin
              if (err_a || err_b) begin
                pend_nxt.status = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = in_node_a[ADDR_W-1:0];
              end
            end
            OP_DEG, OP_LIST: begin
              if (err_a) begin
                pend_nxt.status = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = in_node_a[ADDR_W-1:0];
              end
            end
            OP_CLEAR: valid_nxt = '0;
            OP_COMPL: begin
              rd_en    = 1'b1;
              rd_addr  = '0;
              cidx_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          a_nxt = IN_NODE_W'(a_mod);
          b_nxt = IN_NODE_W'(b_mod);
          if (a_mod != b_mod) begin
            rd_en   = 1'b1;
            rd_addr = a_mod[ADDR_W-1:0];
          end
        end
      end
      S_RD_A: begin
        wr_en   = 1'b1;
        wr_addr = a_r[ADDR_W-1:0];
        wr_data = rd_row | node_bit(b_r[NODE_W-1:0]);
        valid_nxt[a_r[ADDR_W-1:0]] = 1'b1;
        rd_en   = 1'b1;
        rd_addr = b_r[ADDR_W-1:0];
      end
      S_RD_B: begin
        wr_en   = 1'b1;
        wr_addr = b_r[ADDR_W-1:0];
        wr_data = rd_row | node_bit(a_r[NODE_W-1:0]);
        valid_nxt[b_r[ADDR_W-1:0]] = 1'b1;
      end
      S_QRY: begin
        if (op_r == OP_QUERY) begin
          pend_nxt.edge_present = (a_r != b_r) && q_row[b_r[NODE_W-1:0]];
        end else begin
          scan_ctl.start     = 1'b1;
          scan_ctl.list_mode = (op_r == OP_LIST);
        end
      end
      S_SCAN: begin
        load_en  = scan_vld;
        load_res = scan_res;
      end
      S_CMP: begin
        wr_en   = 1'b1;
        wr_addr = cidx_r;
        wr_data = ~rd_row & all_nodes & ~node_bit(NODE_W'(cidx_r));
        valid_nxt[cidx_r] = 1'b1;
        if (cidx_r != ADDR_W'(MAX_NODES - 1)) begin
          rd_en    = 1'b1;
          rd_addr  = cidx_r + 1'b1;
          cidx_nxt = cidx_r + 1'b1;
        end
      end
      S_RES: begin
        load_en = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load_en) begin
      out_res_nxt   = load_res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      node_count_r <= CNT_W'(64);
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_data;
      end
    end
    op_r      <= op_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    cidx_r    <= cidx_nxt;
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
    if (rd_en) begin
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_edge_present   = out_res_r.edge_present;
  assign out_degree         = out_res_r.degree;
  assign out_neighbor       = out_res_r.neighbor;
  assign out_neighbor_valid = out_res_r.neighbor_valid;
  assign out_last           = out_res_r.last;

  `ABM_ASSERT(a_no_rw_same_row, !(wr_en && rd_en && (wr_addr == rd_addr)), "row read and write collide")
  `ABM_ASSERT(a_scan_out_free, !scan_vld || out_free, "scan result with output busy")
  `ABM_ASSERT_NEXT(a_accept_busy, acc, state_r != S_IDLE, "request accepted but unit idle")
  `ABM_ASSERT(a_mod_in_range, !mod_done || ((CNT_W'(a_mod) < n_eff) && (CNT_W'(b_mod) < n_eff)), "remainder not below node count")

endmodule

// ===== dv/tb_adjacency_bit_matrix_unit.sv =====
module tb_adjacency_bit_matrix_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import abm_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam abm_result_t RES_DONE = '{status: 1'b0, edge_present: 1'b0, degree: '0,
                                       neighbor: '0, neighbor_valid: 1'b0, last: 1'b1};
  localparam abm_result_t RES_BAD  = '{status: 1'b1, edge_present: 1'b0, degree: '0,
                                       neighbor: '0, neighbor_valid: 1'b0, last: 1'b1};

  localparam int PHASE_ITEMS = 16;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [IN_NODE_W-1:0] a;
    logic [IN_NODE_W-1:0] b;
    logic                 typed;
    abm_result_t          want;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  // typed rows carry the answer; the rest are checked against the graph model
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{OP_QUERY, 8'd0,   8'd63,  1'b1, RES_DONE},
    '{OP_DEG,   8'd63,  8'd0,   1'b1, RES_DONE},
    '{OP_LIST,  8'd0,   8'd0,   1'b1, RES_DONE},
    '{OP_ADD,   8'd0,   8'd63,  1'b1, RES_DONE},
    '{OP_ADD,   8'd255, 8'd255, 1'b1, RES_DONE},
    '{OP_ADD,   8'd5,   8'd5,   1'b1, RES_DONE},
    '{OP_ADD,   8'd200, 8'd3,   1'b1, RES_DONE},
    '{OP_QUERY, 8'd63,  8'd0,   1'b0, RES_DONE},
    '{OP_QUERY, 8'd8,   8'd3,   1'b0, RES_DONE},
    '{OP_QUERY, 8'd7,   8'd7,   1'b1, RES_DONE},
    '{OP_QUERY, 8'd64,  8'd0,   1'b1, RES_BAD},
    '{OP_QUERY, 8'd0,   8'd255, 1'b1, RES_BAD},
    '{OP_DEG,   8'd0,   8'd0,   1'b0, RES_DONE},
    '{OP_DEG,   8'd64,  8'd0,   1'b1, RES_BAD},
    '{OP_DEG,   8'd255, 8'd0,   1'b1, RES_BAD},
    '{OP_LIST,  8'd0,   8'd0,   1'b0, RES_DONE},
    '{OP_LIST,  8'd255, 8'd0,   1'b1, RES_BAD},
    '{OP_SPARE6, 8'd12, 8'd34,  1'b1, RES_DONE},
    '{OP_SPARE7, 8'd255, 8'd255, 1'b1, RES_DONE},
    '{OP_COMPL, 8'd0,   8'd0,   1'b1, RES_DONE},
    '{OP_LIST,  8'd0,   8'd0,   1'b0, RES_DONE},
    '{OP_DEG,   8'd63,  8'd0,   1'b0, RES_DONE},
    '{OP_QUERY, 8'd0,   8'd63,  1'b0, RES_DONE},
    '{OP_CLEAR, 8'd0,   8'd0,   1'b1, RES_DONE},
    '{OP_DEG,   8'd0,   8'd0,   1'b1, RES_DONE}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode;
  logic [IN_NODE_W-1:0] in_node_a;
  logic [IN_NODE_W-1:0] in_node_b;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_status;
  logic                 out_edge_present;
  logic [NODE_W-1:0]    out_degree;
  logic [NODE_W-1:0]    out_neighbor;
  logic                 out_neighbor_valid;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_data;

  logic [ROW_W-1:0] adj_rows [MAX_NODES];
  logic [CNT_W-1:0] node_count_reg;
  abm_result_t      pending_results [$];
  abm_result_t      want_res;
  int unsigned      fail_count;
  int unsigned      burst_left;
  int unsigned      stall_mode;
  int unsigned      stall_left;

  adjacency_bit_matrix_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_node_a          (in_node_a),
    .in_node_b          (in_node_b),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_edge_present   (out_edge_present),
    .out_degree         (out_degree),
    .out_neighbor       (out_neighbor),
    .out_neighbor_valid (out_neighbor_valid),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int unsigned active_nodes();
    if (node_count_reg == 0) return 1;
    if (node_count_reg > MAX_NODES) return MAX_NODES;
    return 32'(node_count_reg);
  endfunction

  function automatic void apply_graph_op(input logic [OP_W-1:0] op,
                                         input logic [IN_NODE_W-1:0] a,
                                         input logic [IN_NODE_W-1:0] b);
    int unsigned n;
    int unsigned ra;
    int unsigned rb;
    int unsigned cnt;
    logic [ROW_W-1:0] live;
    logic [ROW_W-1:0] row;
    abm_result_t r;
    n = active_nodes();
    live = (n >= ROW_W) ? '1 : ((64'd1 << n) - 64'd1);
    r = RES_DONE;
    case (op)
      OP_ADD: begin
        ra = a % n;
        rb = b % n;
        if (ra != rb) begin
          adj_rows[ra][rb] = 1'b1;
          adj_rows[rb][ra] = 1'b1;
        end
        pending_results.push_back(r);
      end
      OP_QUERY: begin
        if (a >= n || b >= n) r = RES_BAD;
        else r.edge_present = (a == b) ? 1'b0 : adj_rows[a][b];
        pending_results.push_back(r);
      end
      OP_DEG: begin
        if (a >= n) begin
          r = RES_BAD;
        end else begin
          row = adj_rows[a] & live & ~(64'd1 << a);
          cnt = 0;
          for (int i = 0; i < ROW_W; i++) cnt += 32'(row[i]);
          r.degree = cnt[NODE_W-1:0];
        end
        pending_results.push_back(r);
      end
      OP_LIST: begin
        if (a >= n) begin
          pending_results.push_back(RES_BAD);
        end else begin
          row = adj_rows[a] & live & ~(64'd1 << a);
          if (row == '0) pending_results.push_back(r);
          for (int i = 0; i < ROW_W; i++) begin
            if (row[i]) begin
              r.neighbor = i[NODE_W-1:0];
              r.neighbor_valid = 1'b1;
              r.last = ((row >> (i + 1)) == '0);
              pending_results.push_back(r);
            end
          end
        end
      end
      OP_CLEAR: begin
        for (int j = 0; j < MAX_NODES; j++) adj_rows[j] = '0;
        pending_results.push_back(r);
      end
      OP_COMPL: begin
        for (int j = 0; j < MAX_NODES; j++) begin
          adj_rows[j] = ~adj_rows[j];
          adj_rows[j][j] = 1'b0;
        end
        pending_results.push_back(r);
      end
      default: pending_results.push_back(r);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [5:0] want,
                                      input logic [5:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [IN_NODE_W-1:0] a,
                              input logic [IN_NODE_W-1:0] b);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_node_a <= a;
    in_node_b <= b;
    do @(posedge clk); while (in_stall);
    apply_graph_op(op, a, b);
  endtask

  task automatic pace_sender();
    if (burst_left == 0) begin
      in_valid  <= 1'b0;
      in_opcode <= OP_W'($urandom);
      in_node_a <= IN_NODE_W'($urandom);
      in_node_b <= IN_NODE_W'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [CNT_W-1:0] v);
    drain_results();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    node_count_reg = v;
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned n;
    logic [OP_W-1:0] op;
    logic [IN_NODE_W-1:0] a;
    logic [IN_NODE_W-1:0] b;
    n = active_nodes();
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_ADD;
    else if (pick < 55) op = OP_QUERY;
    else if (pick < 67) op = OP_DEG;
    else if (pick < 85) op = OP_LIST;
    else if (pick < 88) op = OP_CLEAR;
    else if (pick < 93) op = OP_COMPL;
    else if (pick < 96) op = OP_SPARE6;
    else op = OP_SPARE7;
    if ($urandom_range(0, 9) == 0) begin
      a = IN_NODE_W'($urandom);
      b = IN_NODE_W'($urandom);
    end else begin
      a = IN_NODE_W'($urandom_range(0, n - 1));
      b = IN_NODE_W'($urandom_range(0, n - 1));
    end
    send_request(op, a, b);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want_res = pending_results.pop_front();
          check_field("status", want_res.status, out_status);
          check_field("edge_present", want_res.edge_present, out_edge_present);
          check_field("degree", want_res.degree, out_degree);
          check_field("neighbor", want_res.neighbor, out_neighbor);
          check_field("neighbor_valid", want_res.neighbor_valid, out_neighbor_valid);
          check_field("last", want_res.last, out_last);
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(10, 120);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  initial begin
    logic [CNT_W-1:0] cfg_list [8];
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_opcode  <= '0;
    in_node_a  <= '0;
    in_node_b  <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    fail_count = 0;
    burst_left = 0;
    node_count_reg = 7'd64;
    for (int j = 0; j < MAX_NODES; j++) adj_rows[j] = '0;
    cfg_list = '{7'd127, 7'd0, 7'd1, 7'd2, 7'd13, 7'd63, 7'd64, 7'd64};
    cfg_list[7] = CNT_W'($urandom_range(3, 127));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b);
      if (dir_tab[i].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(dir_tab[i].want);
      end
      pace_sender();
    end
    in_valid <= 1'b0;
    drain_results();

    for (int p = 0; p < 8; p++) begin
      in_valid <= 1'b0;
      write_node_count(cfg_list[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        random_request();
        pace_sender();
        if (p == 3 && k == 10) begin
          in_valid <= 1'b0;
          drain_results();
        end
      end
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("adjacency_bit_matrix_unit test passed");
    end else begin
      $display("adjacency_bit_matrix_unit test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("adjacency_bit_matrix_unit test failed");
    $finish;
  end

endmodule
